>>> rtl/core/free_extent_list_checker_assert.svh
// Assertion macros shared by the checker RTL.
// Each macro expects clk and arst_n to be visible at the point of use.
`ifndef FREE_EXTENT_LIST_CHECKER_ASSERT_SVH
`define FREE_EXTENT_LIST_CHECKER_ASSERT_SVH

// Same-cycle implication.
`define FELC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("felc assertion failed");

// Next-cycle implication.
`define FELC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("felc assertion failed");

`endif

>>> rtl/core/felc_pkg.sv
`timescale 1ns / 1ps
package felc_pkg;

	localparam int unsigned HEADER_BYTES = 40;
	localparam logic [29:0] LEN_LIMIT    = 30'h3FFF_FFFF;

	localparam logic [3:0] BS_LOG2_MIN   = 4'd9;
	localparam logic [3:0] BS_LOG2_RESET = 4'd11;

	localparam int unsigned IN_DATA_W  = 144;
	localparam int unsigned IN_USER_W  = 3;
	localparam int unsigned OUT_DATA_W = 200;
	localparam int unsigned OUT_USER_W = 2;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_TYPE   = 3'd1,
		ST_MISALIGNED = 3'd2,
		ST_ADJACENT   = 3'd3,
		ST_UNSORTED   = 3'd4,
		ST_BAD_CHAIN  = 3'd5,
		ST_ZERO_LEN   = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		EXT_RECORDED    = 2'd0,
		EXT_ALLOCATED   = 2'd1,
		EXT_UNALLOCATED = 2'd2,
		EXT_CHAIN       = 2'd3
	} ext_type_t;

	typedef struct packed {
		logic        new_table;
		logic [15:0] partition;
		logic [31:0] extent_location;
		logic [29:0] ext_len;
		ext_type_t   ext_kind;
		logic [31:0] descriptor_offset;
		logic [31:0] area_length;
	} desc_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] expected_value;
		logic [31:0] found_value;
		logic        free_valid;
		logic [15:0] free_partition;
		logic [31:0] free_start;
		logic [20:0] free_blocks;
		logic        chain_valid;
		logic [31:0] chain_location;
		logic [29:0] chain_size;
		logic        end_of_list;
	} result_t;

endpackage

>>> rtl/core/free_extent_list_checker.sv
`timescale 1ns / 1ps
// A descriptor is registered in stage 1, then its result is registered in the result stage.
// Throughput: one descriptor per cycle while no result waits on m_tready; the only feedback
// path is the next_allowed_start / unsorted flag update, one 32-bit add and compare per beat.
// Reset (arst_n low, asynchronous): both stages empty, ordering state cleared,
// block_size_log2 back to 11.
module free_extent_list_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration: block_size_log2
	input  logic                                cfg_we,
	input  logic [3:0]                          cfg_data,
	// descriptor beats in
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [15:0] partition, [47:16] extent_location, [77:48] ext_len,
	// [109:78] descriptor_offset, [141:110] area_length, [143:142] zero
	input  logic [felc_pkg::IN_DATA_W-1:0]      s_tdata,
	// [0] new_table, [2:1] ext_kind
	input  logic [felc_pkg::IN_USER_W-1:0]      s_tuser,
	// result beats out
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [2:0] status, [34:3] expected_value, [66:35] found_value,
	// [82:67] free_partition, [114:83] free_start, [135:115] free_blocks,
	// [167:136] chain_location, [197:168] chain_size, [199:198] zero
	output logic [felc_pkg::OUT_DATA_W-1:0]     m_tdata,
	// [0] free_valid, [1] chain_valid
	output logic [felc_pkg::OUT_USER_W-1:0]     m_tuser,
	// end_of_list
	output logic                                m_tlast
);
	import felc_pkg::*;

	`include "free_extent_list_checker_assert.svh"

	// ---------------------------------------------------------------
	// Registers
	// ---------------------------------------------------------------
	logic [3:0]  bs_log2_q;        // configured block size, raw value
	logic [31:0] next_start_q;     // lowest legal start of next allocated extent
	logic        warned_q;         // unsorted error already raised in this table

	logic        valid_s1;
	desc_t       desc_s1;

	logic        valid_s2;
	result_t     res_s2;

	logic        advance;          // stage 1 moves into the result register
	result_t     res_d;
	logic [31:0] next_start_d;
	logic        warned_d;

	// ---------------------------------------------------------------
	// Handshake: stage 1 frees itself whenever the result stage can take
	// its beat; a waiting result stops input only once stage 1 holds a
	// beat as well.
	// ---------------------------------------------------------------
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_log2_q <= BS_LOG2_RESET;
		end else if (cfg_we) begin
			bs_log2_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			next_start_q <= '0;
			warned_q     <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2     <= 1'b1;
				next_start_q <= next_start_d;
				warned_q     <= warned_d;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			desc_s1.new_table         <= s_tuser[0];
			desc_s1.ext_kind          <= ext_type_t'(s_tuser[2:1]);
			desc_s1.partition         <= s_tdata[15:0];
			desc_s1.extent_location   <= s_tdata[47:16];
			desc_s1.ext_len           <= s_tdata[77:48];
			desc_s1.descriptor_offset <= s_tdata[109:78];
			desc_s1.area_length       <= s_tdata[141:110];
		end
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	// ---------------------------------------------------------------
	// Check logic
	// ---------------------------------------------------------------
	logic [3:0]  sh;            // clamped log2 block size, 9..15
	logic [16:0] bs;            // block size in bytes
	logic [29:0] mask;          // byte offset within block
	logic [29:0] maxlen;        // longest length that is whole blocks
	logic [20:0] blocks;
	logic [31:0] cur_start;     // ordering state after an optional table restart
	logic        cur_warned;
	logic [31:0] aligned_up;

	always_comb begin
		// values above 15 cannot be written into four bits
		sh         = (bs_log2_q < BS_LOG2_MIN) ? BS_LOG2_MIN : bs_log2_q;
		bs         = 17'd1 << sh;
		mask       = {13'd0, bs} - 30'd1;
		maxlen     = LEN_LIMIT & ~mask;
		blocks     = 21'(desc_s1.ext_len >> sh);
		aligned_up = {2'b00, desc_s1.ext_len & ~mask} + {15'd0, bs};

		cur_start  = desc_s1.new_table ? 32'd0 : next_start_q;
		cur_warned = desc_s1.new_table ? 1'b0 : warned_q;

		next_start_d = cur_start;
		warned_d     = cur_warned;
		res_d        = '0;
		res_d.status = ST_OK;

		if (desc_s1.ext_len == 30'd0) begin
			// zero length ends the table, the type is ignored
			res_d.status         = ST_ZERO_LEN;
			res_d.expected_value = desc_s1.area_length;
			res_d.found_value    = desc_s1.descriptor_offset;
			res_d.end_of_list    = 1'b1;
		end else begin
			unique case (desc_s1.ext_kind)
				EXT_ALLOCATED: begin
					if ((desc_s1.ext_len & mask) != 30'd0) begin
						res_d.status         = ST_MISALIGNED;
						res_d.expected_value = aligned_up;
						res_d.found_value    = {2'b00, desc_s1.ext_len};
					end else if (desc_s1.extent_location < cur_start) begin
						if (desc_s1.extent_location == cur_start - 32'd1) begin
							res_d.status         = ST_ADJACENT;
							res_d.expected_value = cur_start;
							res_d.found_value    = desc_s1.extent_location;
						end else begin
							// only the first unsorted extent of a table is reported
							if (!cur_warned) begin
								res_d.status         = ST_UNSORTED;
								res_d.expected_value = cur_start;
								res_d.found_value    = desc_s1.extent_location;
							end
							warned_d = 1'b1;
						end
					end else begin
						// a maximum-length extent may be followed directly
						next_start_d = desc_s1.extent_location + {11'd0, blocks}
							+ {31'd0, (desc_s1.ext_len < maxlen)};
					end
					// flagged or not, the run is reported
					res_d.free_valid     = 1'b1;
					res_d.free_partition = desc_s1.partition;
					res_d.free_start     = desc_s1.extent_location;
					res_d.free_blocks    = blocks;
				end
				EXT_CHAIN: begin
					if ({13'd0, bs} < desc_s1.ext_len
						|| desc_s1.ext_len < 30'(HEADER_BYTES)) begin
						res_d.status         = ST_BAD_CHAIN;
						res_d.expected_value = {15'd0, bs};
						res_d.found_value    = {2'b00, desc_s1.ext_len};
					end
					res_d.chain_valid    = 1'b1;
					res_d.chain_location = desc_s1.extent_location;
					res_d.chain_size     = desc_s1.ext_len;
					res_d.end_of_list    = 1'b1;
				end
				EXT_RECORDED, EXT_UNALLOCATED: begin
					res_d.status         = ST_BAD_TYPE;
					res_d.expected_value = 32'd1;
					res_d.found_value    = {30'd0, desc_s1.ext_kind};
				end
				default: begin
					res_d.status = ST_OK;
				end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Output packing
	// ---------------------------------------------------------------
	assign m_tvalid = valid_s2;
	assign m_tlast  = res_s2.end_of_list;
	assign m_tuser  = {res_s2.chain_valid, res_s2.free_valid};
	assign m_tdata  = {2'b00,
		res_s2.chain_size,
		res_s2.chain_location,
		res_s2.free_blocks,
		res_s2.free_start,
		res_s2.free_partition,
		res_s2.found_value,
		res_s2.expected_value,
		res_s2.status};

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`FELC_ASSERT_NOW(a_run_xor_chain, valid_s2, !(res_s2.free_valid && res_s2.chain_valid))
	`FELC_ASSERT_NOW(a_chain_ends_list, valid_s2 && res_s2.chain_valid, res_s2.end_of_list)
	`FELC_ASSERT_NEXT(a_unsorted_sets_flag, advance && res_d.status == ST_UNSORTED, warned_q)
	`FELC_ASSERT_NOW(a_ok_no_values, valid_s2 && res_s2.status == ST_OK,
		res_s2.expected_value == 32'd0 && res_s2.found_value == 32'd0)

endmodule
